/* hw/rtl/fehp_pkg.sv */
// shared constants, types and register codes of the fire effect heat propagator
package fehp_pkg;

  // frame geometry
  localparam int MAX_WIDTH  = 512;
  localparam int MAX_HEIGHT = 256;
  localparam int MIN_DIM    = 2;

  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int ROW_W     = $clog2(MAX_HEIGHT);
  localparam int ADDR_W    = ROW_W + COL_W;
  localparam int MEM_DEPTH = MAX_HEIGHT * (2 ** COL_W);
  localparam int WCNT_W    = $clog2(MAX_WIDTH + 1);
  localparam int HCNT_W    = $clog2(MAX_HEIGHT + 1);

  // configuration port
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 10;
  localparam int CFG_WIDTH_W  = 10;
  localparam int CFG_HEIGHT_W = 9;
  localparam int RESET_WIDTH  = 400;
  localparam int RESET_HEIGHT = 200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1
  } cfg_reg_e;

  // payload field widths
  localparam int SPARK_W   = 8;
  localparam int DECAY_W   = 2;
  localparam int HEAT_W    = 8;
  localparam int ROW_OUT_W = 8;
  localparam int COL_OUT_W = 9;
  localparam int COLOR_W   = 8;
  localparam int BLUE_W    = 7;
  localparam int ALPHA_W   = 7;
  localparam int SUM_W     = HEAT_W + 2;

  // palette
  localparam int ALPHA_ON   = 70;
  localparam int BLUE_MAX   = 80;
  localparam int RED_MAX    = 255;
  localparam int BLUE_RECIP = 171;  // 171 / 512 gives an exact floor of h / 3 for 8-bit h
  localparam int BLUE_SHIFT = 9;
  localparam int PROD_W     = 16;

  // result queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    PHASE_SPARK,
    PHASE_PROPAGATE
  } scan_phase_e;

  // one cell on its way through the read-modify-write pipeline
  typedef struct packed {
    logic               spark;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               left_ok;
    logic               right_ok;
    logic               below2_ok;
    logic               done;
    logic [SPARK_W-1:0] spark_heat;
    logic [DECAY_W-1:0] decay;
  } cell_job_t;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    addr;
    logic [HEAT_W-1:0]    data;
  } ram_wr_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [HEAT_W-1:0]    heat;
    logic                 done;
  } result_t;

endpackage

/* hw/rtl/fehp_heat_ram.sv */
// heat frame memory, one write port and two registered read ports
module fehp_heat_ram (
  input  logic                          clk_i,
  input  fehp_pkg::ram_wr_t             wr_i,
  input  logic [fehp_pkg::ADDR_W-1:0]   raddr0_i,
  input  logic [fehp_pkg::ADDR_W-1:0]   raddr1_i,
  output logic [fehp_pkg::HEAT_W-1:0]   rdata0_o,
  output logic [fehp_pkg::HEAT_W-1:0]   rdata1_o
);

  logic [fehp_pkg::HEAT_W-1:0] mem_q [fehp_pkg::MEM_DEPTH];
  logic [fehp_pkg::HEAT_W-1:0] rdata0_q;
  logic [fehp_pkg::HEAT_W-1:0] rdata1_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata0_q <= mem_q[raddr0_i];
    rdata1_q <= mem_q[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

/* hw/rtl/fehp_scan_ctrl.sv */
// scan sequencer: configuration, frame position, admission credits and clearing sweep
module fehp_scan_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [fehp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fehp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fehp_pkg::SPARK_W-1:0]      spark_heat_i,
  input  logic [fehp_pkg::DECAY_W-1:0]      decay_amount_i,
  input  logic                              pipe_busy_i,
  input  logic                              pop_i,
  output logic                              accept_o,
  output fehp_pkg::cell_job_t               job_o,
  output logic                              clr_busy_o,
  output logic [fehp_pkg::ADDR_W-1:0]       clr_addr_o
);

  logic [fehp_pkg::CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [fehp_pkg::CFG_HEIGHT_W-1:0] cfg_height_q;
  fehp_pkg::scan_phase_e             phase_q, phase_d;
  logic [fehp_pkg::COL_W-1:0]        col_q, col_d;
  logic [fehp_pkg::ROW_W-1:0]        row_q, row_d;
  logic [fehp_pkg::QCNT_W-1:0]       inflight_q, inflight_d;
  logic                              clr_busy_q;
  logic [fehp_pkg::ADDR_W-1:0]       clr_addr_q;

  logic [fehp_pkg::WCNT_W-1:0] eff_w;
  logic [fehp_pkg::HCNT_W-1:0] eff_h;
  logic [fehp_pkg::COL_W-1:0]  col_g;
  logic [fehp_pkg::ROW_W-1:0]  row_g;
  logic                        last_col;
  logic                        last_row;
  logic                        cfg_hit;

  // saturate the size registers to the frame limits
  always_comb begin
    eff_w = fehp_pkg::WCNT_W'(cfg_width_q);
    if (int'(cfg_width_q) < fehp_pkg::MIN_DIM) begin
      eff_w = fehp_pkg::WCNT_W'(fehp_pkg::MIN_DIM);
    end else if (int'(cfg_width_q) > fehp_pkg::MAX_WIDTH) begin
      eff_w = fehp_pkg::WCNT_W'(fehp_pkg::MAX_WIDTH);
    end
    eff_h = fehp_pkg::HCNT_W'(cfg_height_q);
    if (int'(cfg_height_q) < fehp_pkg::MIN_DIM) begin
      eff_h = fehp_pkg::HCNT_W'(fehp_pkg::MIN_DIM);
    end else if (int'(cfg_height_q) > fehp_pkg::MAX_HEIGHT) begin
      eff_h = fehp_pkg::HCNT_W'(fehp_pkg::MAX_HEIGHT);
    end
  end

  assign cfg_hit = cfg_we_i && (cfg_index_i == fehp_pkg::REG_ACTIVE_WIDTH ||
                                cfg_index_i == fehp_pkg::REG_ACTIVE_HEIGHT);

  assign in_ready_o = !clr_busy_q && !pipe_busy_i &&
                      (inflight_q < fehp_pkg::QCNT_W'(fehp_pkg::QUEUE_DEPTH));
  assign accept_o   = in_valid_i && in_ready_o;

  // position of the current cell and its edge flags
  always_comb begin
    col_g    = (int'(col_q) >= int'(eff_w)) ? '0 : col_q;
    row_g    = (int'(row_q) + 2 > int'(eff_h)) ? '0 : row_q;
    last_col = (int'(col_g) + 1 >= int'(eff_w));
    last_row = (int'(row_g) + 2 >= int'(eff_h));

    job_o.spark      = (phase_q == fehp_pkg::PHASE_SPARK);
    job_o.row        = job_o.spark ? fehp_pkg::ROW_W'(eff_h - fehp_pkg::HCNT_W'(1)) : row_g;
    job_o.col        = col_g;
    job_o.left_ok    = (col_g != '0);
    job_o.right_ok   = !last_col;
    job_o.below2_ok  = !last_row;
    job_o.done       = !job_o.spark && last_col && last_row;
    job_o.spark_heat = spark_heat_i;
    job_o.decay      = decay_amount_i;
  end

  // next scan position
  always_comb begin
    phase_d = phase_q;
    col_d   = col_q;
    row_d   = row_q;
    if (cfg_hit) begin
      phase_d = fehp_pkg::PHASE_SPARK;
      col_d   = '0;
      row_d   = '0;
    end else if (accept_o) begin
      case (phase_q)
        fehp_pkg::PHASE_SPARK: begin
          if (last_col) begin
            col_d   = '0;
            row_d   = '0;
            phase_d = fehp_pkg::PHASE_PROPAGATE;
          end else begin
            col_d = col_g + fehp_pkg::COL_W'(1);
          end
        end
        fehp_pkg::PHASE_PROPAGATE: begin
          if (last_col) begin
            col_d = '0;
            if (last_row) begin
              row_d   = '0;
              phase_d = fehp_pkg::PHASE_SPARK;
            end else begin
              row_d = row_g + fehp_pkg::ROW_W'(1);
            end
          end else begin
            col_d = col_g + fehp_pkg::COL_W'(1);
            row_d = row_g;
          end
        end
        default: begin
          phase_d = fehp_pkg::PHASE_SPARK;
        end
      endcase
    end
  end

  always_comb begin
    case ({accept_o, pop_i})
      2'b10:   inflight_d = inflight_q + fehp_pkg::QCNT_W'(1);
      2'b01:   inflight_d = inflight_q - fehp_pkg::QCNT_W'(1);
      default: inflight_d = inflight_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= fehp_pkg::CFG_WIDTH_W'(fehp_pkg::RESET_WIDTH);
      cfg_height_q <= fehp_pkg::CFG_HEIGHT_W'(fehp_pkg::RESET_HEIGHT);
      phase_q      <= fehp_pkg::PHASE_SPARK;
      col_q        <= '0;
      row_q        <= '0;
      inflight_q   <= '0;
      clr_busy_q   <= 1'b1;
      clr_addr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          fehp_pkg::REG_ACTIVE_WIDTH:  cfg_width_q  <= cfg_wdata_i[fehp_pkg::CFG_WIDTH_W-1:0];
          fehp_pkg::REG_ACTIVE_HEIGHT: cfg_height_q <= cfg_wdata_i[fehp_pkg::CFG_HEIGHT_W-1:0];
          default: ;
        endcase
      end
      phase_q    <= phase_d;
      col_q      <= col_d;
      row_q      <= row_d;
      inflight_q <= inflight_d;
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + fehp_pkg::ADDR_W'(1);
        if (clr_addr_q == fehp_pkg::ADDR_W'(fehp_pkg::MEM_DEPTH - 1)) begin
          clr_busy_q <= 1'b0;
        end
      end
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign clr_addr_o = clr_addr_q;

endmodule

/* hw/rtl/fehp_out_queue.sv */
// result queue with palette lookup on the head entry
module fehp_out_queue (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  fehp_pkg::result_t                push_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fehp_pkg::ROW_OUT_W-1:0]   cell_row_o,
  output logic [fehp_pkg::COL_OUT_W-1:0]   cell_column_o,
  output logic [fehp_pkg::HEAT_W-1:0]      heat_value_o,
  output logic [fehp_pkg::COLOR_W-1:0]     red_level_o,
  output logic [fehp_pkg::COLOR_W-1:0]     green_level_o,
  output logic [fehp_pkg::BLUE_W-1:0]      blue_level_o,
  output logic [fehp_pkg::ALPHA_W-1:0]     alpha_level_o,
  output logic                             frame_done_o
);

  fehp_pkg::result_t              entry_q [fehp_pkg::QUEUE_DEPTH];
  logic [fehp_pkg::QPTR_W-1:0]    wr_ptr_q;
  logic [fehp_pkg::QPTR_W-1:0]    rd_ptr_q;
  logic [fehp_pkg::QCNT_W-1:0]    count_q;
  fehp_pkg::result_t              head;
  logic                           pop;
  logic [fehp_pkg::PROD_W-1:0]    blue_prod;
  logic [fehp_pkg::BLUE_W-1:0]    blue_raw;

  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o && out_ready_i;
  assign head        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + fehp_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + fehp_pkg::QPTR_W'(1);
      end
      case ({push_i, pop})
        2'b10:   count_q <= count_q + fehp_pkg::QCNT_W'(1);
        2'b01:   count_q <= count_q - fehp_pkg::QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

  // palette: red saturates at twice the heat, blue is a third of it, capped
  always_comb begin
    blue_prod = fehp_pkg::PROD_W'(head.heat) * fehp_pkg::PROD_W'(fehp_pkg::BLUE_RECIP);
    blue_raw  = blue_prod[fehp_pkg::BLUE_SHIFT +: fehp_pkg::BLUE_W];
    if (head.heat[fehp_pkg::HEAT_W-1]) begin
      red_level_o = fehp_pkg::COLOR_W'(fehp_pkg::RED_MAX);
    end else begin
      red_level_o = {head.heat[fehp_pkg::HEAT_W-2:0], 1'b0};
    end
    if (int'(blue_raw) > fehp_pkg::BLUE_MAX) begin
      blue_level_o = fehp_pkg::BLUE_W'(fehp_pkg::BLUE_MAX);
    end else begin
      blue_level_o = blue_raw;
    end
    alpha_level_o = (head.heat != '0) ? fehp_pkg::ALPHA_W'(fehp_pkg::ALPHA_ON) : '0;
  end

  assign cell_row_o    = head.row;
  assign cell_column_o = head.col;
  assign heat_value_o  = head.heat;
  assign green_level_o = head.heat;
  assign frame_done_o  = head.done;

endmodule

/* hw/rtl/fire_effect_heat_propagator_core.sv */
// top level of the fire effect heat propagator
//
// one input transaction updates one cell of the 8-bit heat frame and yields one output
// transaction with the cell position, new heat, palette color, alpha and an end-of-frame
// flag. a frame visits the bottom row first (cells take spark_heat), then rows 0 to
// height-2 left to right, each cell becoming the quarter of the sum of its three
// neighbors below and the cell two rows below, less decay_amount, floored at zero.
// the block takes no new cell while the last one is in s1: the four neighbor reads
// share the two read ports of the heat memory, one pair in s1 and one in s2. each
// result waits in a four-entry queue, so the input side keeps going while the output
// side stalls until the queue is full. after reset the frame memory is zeroed by a
// clearing pass over all 131072 entries (MAX_HEIGHT rows of 512 entries) during which
// in_ready_o stays low; configuration writes are taken at any time. a write to either
// size register restarts the scan at the bottom row, column 0, and keeps stored heat
module fire_effect_heat_propagator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [fehp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [fehp_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fehp_pkg::SPARK_W-1:0]      spark_heat_i,
  input  logic [fehp_pkg::DECAY_W-1:0]      decay_amount_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fehp_pkg::ROW_OUT_W-1:0]    cell_row_o,
  output logic [fehp_pkg::COL_OUT_W-1:0]    cell_column_o,
  output logic [fehp_pkg::HEAT_W-1:0]       heat_value_o,
  output logic [fehp_pkg::COLOR_W-1:0]      red_level_o,
  output logic [fehp_pkg::COLOR_W-1:0]      green_level_o,
  output logic [fehp_pkg::BLUE_W-1:0]       blue_level_o,
  output logic [fehp_pkg::ALPHA_W-1:0]      alpha_level_o,
  output logic                              frame_done_o
);

  logic                           accept;
  fehp_pkg::cell_job_t            job;
  logic                           clr_busy;
  logic [fehp_pkg::ADDR_W-1:0]    clr_addr;
  logic                           pop;

  // pipeline: s1 issues the first read pair, s2 the second, s3 computes and writes back
  logic                           s1_valid_q, s2_valid_q, s3_valid_q;
  fehp_pkg::cell_job_t            s1_job_q, s2_job_q, s3_job_q;
  logic [fehp_pkg::HEAT_W-1:0]    below_q;    // cell directly below
  logic [fehp_pkg::HEAT_W-1:0]    below2_q;   // cell two rows below

  logic [fehp_pkg::ADDR_W-1:0]    raddr0, raddr1;
  logic [fehp_pkg::HEAT_W-1:0]    rdata0, rdata1;
  fehp_pkg::ram_wr_t              ram_wr;

  logic [fehp_pkg::SUM_W-1:0]     nb_sum;
  logic [fehp_pkg::HEAT_W-1:0]    nb_avg;
  logic [fehp_pkg::HEAT_W-1:0]    decay_ext;
  logic [fehp_pkg::HEAT_W-1:0]    new_heat;
  fehp_pkg::result_t              result;

  assign pop = out_valid_o && out_ready_i;

  fehp_scan_ctrl u_scan_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .spark_heat_i   (spark_heat_i),
    .decay_amount_i (decay_amount_i),
    .pipe_busy_i    (s1_valid_q),
    .pop_i          (pop),
    .accept_o       (accept),
    .job_o          (job),
    .clr_busy_o     (clr_busy),
    .clr_addr_o     (clr_addr)
  );

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  // pipeline payload; the first read pair is held while the second comes back
  always_ff @(posedge clk_i) begin
    s1_job_q <= job;
    s2_job_q <= s1_job_q;
    s3_job_q <= s2_job_q;
    if (s2_valid_q) begin
      below_q  <= rdata0;
      below2_q <= rdata1;
    end
  end

  // s1 and s2 never hold a cell in the same cycle, so the ports are shared by phase.
  // the right neighbor is read in the second phase: after a spark row the write of
  // its last cell has landed by then even at the narrowest width
  always_comb begin
    if (s2_valid_q) begin
      raddr0 = {s2_job_q.row + fehp_pkg::ROW_W'(1), s2_job_q.col + fehp_pkg::COL_W'(1)};
      raddr1 = {s2_job_q.row + fehp_pkg::ROW_W'(1), s2_job_q.col - fehp_pkg::COL_W'(1)};
    end else begin
      raddr0 = {s1_job_q.row + fehp_pkg::ROW_W'(1), s1_job_q.col};
      raddr1 = {s1_job_q.row + fehp_pkg::ROW_W'(2), s1_job_q.col};
    end
  end

  // neighbors outside the frame count as zero, the sum is still divided by four
  always_comb begin
    nb_sum = fehp_pkg::SUM_W'(below_q)
           + (s3_job_q.below2_ok ? fehp_pkg::SUM_W'(below2_q) : '0)
           + (s3_job_q.right_ok  ? fehp_pkg::SUM_W'(rdata0)   : '0)
           + (s3_job_q.left_ok   ? fehp_pkg::SUM_W'(rdata1)   : '0);
    nb_avg    = nb_sum[fehp_pkg::SUM_W-1:2];
    decay_ext = fehp_pkg::HEAT_W'(s3_job_q.decay);
    if (s3_job_q.spark) begin
      new_heat = s3_job_q.spark_heat;
    end else if (nb_avg > decay_ext) begin
      new_heat = nb_avg - decay_ext;
    end else begin
      new_heat = '0;
    end
  end

  // write port: clearing sweep after reset, then the write-back of s3
  always_comb begin
    if (clr_busy) begin
      ram_wr.we   = 1'b1;
      ram_wr.addr = clr_addr;
      ram_wr.data = '0;
    end else begin
      ram_wr.we   = s3_valid_q;
      ram_wr.addr = {s3_job_q.row, s3_job_q.col};
      ram_wr.data = new_heat;
    end
  end

  fehp_heat_ram u_heat_ram (
    .clk_i    (clk_i),
    .wr_i     (ram_wr),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (rdata0),
    .rdata1_o (rdata1)
  );

  always_comb begin
    result.row  = fehp_pkg::ROW_OUT_W'(s3_job_q.row);
    result.col  = fehp_pkg::COL_OUT_W'(s3_job_q.col);
    result.heat = new_heat;
    result.done = s3_job_q.done;
  end

  // admission credits in the scan sequencer keep this queue from overflowing
  fehp_out_queue u_out_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (s3_valid_q),
    .push_data_i   (result),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .cell_row_o    (cell_row_o),
    .cell_column_o (cell_column_o),
    .heat_value_o  (heat_value_o),
    .red_level_o   (red_level_o),
    .green_level_o (green_level_o),
    .blue_level_o  (blue_level_o),
    .alpha_level_o (alpha_level_o),
    .frame_done_o  (frame_done_o)
  );

endmodule

/* hw/rtl/fehp_checker.sv */
// port-level checker of the fire effect heat propagator and its bind
module fehp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [fehp_pkg::COL_OUT_W-1:0]   cell_column_o,
  input logic [fehp_pkg::HEAT_W-1:0]      heat_value_o,
  input logic [fehp_pkg::COLOR_W-1:0]     red_level_o,
  input logic [fehp_pkg::COLOR_W-1:0]     green_level_o,
  input logic [fehp_pkg::ALPHA_W-1:0]     alpha_level_o,
  input logic                             frame_done_o
);

  logic seen_in_q;
  logic done_pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q      <= 1'b0;
      done_pending_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        seen_in_q <= 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        done_pending_q <= frame_done_o;
      end
    end
  end

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(heat_value_o) && $stable(cell_column_o))
    else $error("result changed while stalled");

  // palette follows the heat of the same transaction
  a_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (green_level_o == heat_value_o) &&
                    ((alpha_level_o != '0) == (heat_value_o != '0)) &&
                    (red_level_o >= heat_value_o))
    else $error("palette does not match heat");

  // no result without an input transaction before it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_in_q)
    else $error("result before any input");

  // a new frame starts at column zero
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && done_pending_q |-> cell_column_o == '0)
    else $error("frame did not restart at column zero");

endmodule

bind fire_effect_heat_propagator_core fehp_checker u_fehp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_o    (in_ready_o),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .cell_column_o (cell_column_o),
  .heat_value_o  (heat_value_o),
  .red_level_o   (red_level_o),
  .green_level_o (green_level_o),
  .alpha_level_o (alpha_level_o),
  .frame_done_o  (frame_done_o)
);

/* verif/fire_effect_heat_propagator_core_tb.sv */
// testbench for the fire effect heat propagator: random cells checked against a built-in frame predictor
module fire_effect_heat_propagator_core_tb;
  import fehp_pkg::*;

  // the clearing pass after reset keeps in_ready_o low for a full frame memory sweep,
  // so the no-progress limit sits well above it
  localparam int unsigned STALL_LIMIT  = 524288;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned IDLE_PERCENT = 18;
  localparam int unsigned RANDOM_ITEMS = 1850;

  // one input transaction
  typedef struct {
    logic [SPARK_W-1:0] spark;
    logic [DECAY_W-1:0] decay;
  } fire_cell_t;

  // one output transaction as the predictor sees it
  typedef struct {
    logic [ROW_OUT_W-1:0] row;
    logic [COL_OUT_W-1:0] col;
    logic [HEAT_W-1:0]    heat;
    logic [COLOR_W-1:0]   red;
    logic [COLOR_W-1:0]   green;
    logic [BLUE_W-1:0]    blue;
    logic [ALPHA_W-1:0]   alpha;
    logic                 done;
  } fire_pixel_t;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i    = REG_ACTIVE_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_wdata_i    = '0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [SPARK_W-1:0]    spark_heat_i   = '0;
  logic [DECAY_W-1:0]    decay_amount_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic [ROW_OUT_W-1:0]  cell_row_o;
  logic [COL_OUT_W-1:0]  cell_column_o;
  logic [HEAT_W-1:0]     heat_value_o;
  logic [COLOR_W-1:0]    red_level_o;
  logic [COLOR_W-1:0]    green_level_o;
  logic [BLUE_W-1:0]     blue_level_o;
  logic [ALPHA_W-1:0]    alpha_level_o;
  logic                  frame_done_o;

  fire_effect_heat_propagator_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .spark_heat_i   (spark_heat_i),
    .decay_amount_i (decay_amount_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cell_row_o     (cell_row_o),
    .cell_column_o  (cell_column_o),
    .heat_value_o   (heat_value_o),
    .red_level_o    (red_level_o),
    .green_level_o  (green_level_o),
    .blue_level_o   (blue_level_o),
    .alpha_level_o  (alpha_level_o),
    .frame_done_o   (frame_done_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // stimulus and result bookkeeping
  fire_cell_t  pending_cells[$];
  fire_pixel_t expected_pixels[$];
  int unsigned error_count  = 0;
  int unsigned random_count = 0;
  int unsigned idle_cycles  = 0;
  int unsigned hold_left    = 0;
  bit          steady       = 1'b0;  // no random idling on either side
  bit          hold_req     = 1'b0;  // ask the receiver for one long hold-off
  bit          hold_done    = 1'b0;

  // predictor copy of the frame, scan position and size registers
  logic [HEAT_W-1:0] frame_heat [MEM_DEPTH];
  int unsigned       scan_col     = 0;
  int unsigned       scan_row     = 0;
  bit                in_spark_row = 1'b1;
  int unsigned       width_reg    = RESET_WIDTH;
  int unsigned       height_reg   = RESET_HEIGHT;

  initial begin
    foreach (frame_heat[i]) frame_heat[i] = '0;
  end

  // register value saturated to the usable frame size
  function automatic int unsigned clamp_dim(int unsigned value, int unsigned top);
    if (value < MIN_DIM) return MIN_DIM;
    if (value > top) return top;
    return value;
  endfunction

  // neighbor outside the active frame reads as cold
  function automatic int unsigned heat_at(int unsigned row, int unsigned col,
                                          int unsigned w, int unsigned h);
    if (row >= h || col >= w) return 0;
    return frame_heat[ADDR_W'(row * MAX_WIDTH + col)];
  endfunction

  // update one cell of the frame copy and queue the pixel it must produce
  task automatic predict_cell(input logic [SPARK_W-1:0] spark, input logic [DECAY_W-1:0] decay);
    int unsigned w, h, col, row, sum, heat;
    logic        last;
    fire_pixel_t px;
    w    = clamp_dim(width_reg, MAX_WIDTH);
    h    = clamp_dim(height_reg, MAX_HEIGHT);
    col  = (scan_col >= w) ? 0 : scan_col;
    last = 1'b0;
    if (in_spark_row) begin
      // bottom row takes the spark as is
      row  = h - 1;
      heat = spark;
      if (col + 1 >= w) begin
        scan_col     = 0;
        scan_row     = 0;
        in_spark_row = 1'b0;
      end else begin
        scan_col = col + 1;
      end
    end else begin
      row = (scan_row > h - 2) ? 0 : scan_row;
      sum = heat_at(row + 1, col, w, h) + heat_at(row + 2, col, w, h)
          + heat_at(row + 1, col + 1, w, h);
      if (col > 0) sum += heat_at(row + 1, col - 1, w, h);
      // edges still divide by four; decay floors at zero
      heat = sum / 4;
      heat = (heat > decay) ? heat - decay : 0;
      if (col + 1 >= w) begin
        scan_col = 0;
        if (row + 1 >= h - 1) begin
          scan_row     = 0;
          in_spark_row = 1'b1;
          last         = 1'b1;
        end else begin
          scan_row = row + 1;
        end
      end else begin
        scan_col = col + 1;
        scan_row = row;
      end
    end
    frame_heat[ADDR_W'(row * MAX_WIDTH + col)] = heat[HEAT_W-1:0];
    px.row   = row[ROW_OUT_W-1:0];
    px.col   = col[COL_OUT_W-1:0];
    px.heat  = heat[HEAT_W-1:0];
    px.red   = COLOR_W'((heat * 2 > RED_MAX) ? RED_MAX : heat * 2);
    px.green = heat[HEAT_W-1:0];
    px.blue  = BLUE_W'((heat / 3 > BLUE_MAX) ? BLUE_MAX : heat / 3);
    px.alpha = ALPHA_W'((heat != 0) ? ALPHA_ON : 0);
    px.done  = last;
    expected_pixels.push_back(px);
  endtask

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      error_count++;
    end
  endfunction

  // driver: presents queued cells, holds valid until the transaction is taken
  always @(posedge clk_i) begin
    fire_cell_t nxt;
    logic       send;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      send = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        predict_cell(spark_heat_i, decay_amount_i);
        send = 1'b0;
      end
      if (!send && pending_cells.size() != 0 &&
          (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
        nxt            = pending_cells.pop_front();
        spark_heat_i   <= nxt.spark;
        decay_amount_i <= nxt.decay;
        send           = 1'b1;
      end
      in_valid_i <= send;
    end
  end

  // monitor: checks each output transaction and throttles out_ready_i
  always @(posedge clk_i) begin
    fire_pixel_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none actual row %0d col %0d heat %0d",
                   $time, cell_row_o, cell_column_o, heat_value_o);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("cell_row", want.row, cell_row_o);
          check_field("cell_column", want.col, cell_column_o);
          check_field("heat_value", want.heat, heat_value_o);
          check_field("red_level", want.red, red_level_o);
          check_field("green_level", want.green, green_level_o);
          check_field("blue_level", want.blue, blue_level_o);
          check_field("alpha_level", want.alpha, alpha_level_o);
          check_field("frame_done", want.done, frame_done_o);
        end
      end
      // one long hold-off so the result queue fills and the input side backs up
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(99) >= IDLE_PERCENT);
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic push_cell(input logic [SPARK_W-1:0] spark, input logic [DECAY_W-1:0] decay);
    fire_cell_t c;
    c.spark = spark;
    c.decay = decay;
    pending_cells.push_back(c);
  endtask

  // nothing queued, nothing on the input port, nothing outstanding; sampled mid-cycle
  // so the driver's updates of this edge have settled
  task automatic wait_drain();
    do
      @(negedge clk_i);
    while (pending_cells.size() != 0 || in_valid_i || expected_pixels.size() != 0);
  endtask

  // size registers are only touched with the block idle; a write restarts the scan
  task automatic write_size_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_ACTIVE_WIDTH) width_reg = value[CFG_WIDTH_W-1:0];
    else height_reg = value[CFG_HEIGHT_W-1:0];
    scan_col     = 0;
    scan_row     = 0;
    in_spark_row = 1'b1;
  endtask

  task automatic set_frame(input int unsigned w, input int unsigned h);
    wait_drain();
    write_size_reg(REG_ACTIVE_WIDTH, CFG_DATA_W'(w));
    write_size_reg(REG_ACTIVE_HEIGHT, CFG_DATA_W'(h));
  endtask

  // new frame size, then a run of random cells; hot and cold sparks favored a bit
  task automatic run_phase(input int unsigned w, input int unsigned h, input int unsigned n);
    int unsigned pick;
    logic [SPARK_W-1:0] spark;
    logic [DECAY_W-1:0] decay;
    set_frame(w, h);
    repeat (n) begin
      pick  = $urandom_range(9);
      spark = (pick == 0) ? '0 : (pick == 1) ? '1 : SPARK_W'($urandom_range(255));
      decay = ($urandom_range(9) == 0) ? 2'd3 : DECAY_W'($urandom_range(2));
      push_cell(spark, decay);
    end
    random_count += n;
  endtask

  task automatic run_small_phases(input int unsigned target);
    int unsigned w, h, n;
    while (random_count < target) begin
      // 0 and 1 saturate up to the two-cell minimum
      w = $urandom_range(9);
      h = $urandom_range(8);
      n = clamp_dim(w, MAX_WIDTH) * clamp_dim(h, MAX_HEIGHT) * $urandom_range(1, 3)
        + $urandom_range(3);
      run_phase(w, h, n);
    end
  endtask

  initial begin
    // reset size, bottom row only; queued cells wait out the clearing pass
    push_cell(8'h00, 2'd0);
    push_cell(8'hFF, 2'd3);
    push_cell(8'hAA, 2'd1);
    push_cell(8'h55, 2'd2);

    // 3x3 full frame: saturated sparks, every decay including 3, both edges, frame end
    set_frame(3, 3);
    push_cell(8'hFF, 2'd0);
    push_cell(8'hFF, 2'd1);
    push_cell(8'hFF, 2'd2);
    push_cell(8'h00, 2'd0);
    push_cell(8'h00, 2'd1);
    push_cell(8'h00, 2'd2);
    push_cell(8'h00, 2'd3);
    push_cell(8'h00, 2'd2);
    push_cell(8'h00, 2'd3);

    // out-of-range low sizes saturate to 2x2; two frames so stored heat is reused
    set_frame(0, 1);
    push_cell(8'd200, 2'd3);
    push_cell(8'd1, 2'd0);
    push_cell(8'h00, 2'd3);
    push_cell(8'h00, 2'd3);
    push_cell(8'd3, 2'd0);
    push_cell(8'd240, 2'd0);
    push_cell(8'h00, 2'd0);
    push_cell(8'h00, 2'd1);

    // widest frame via an out-of-range width, with the receiver holding off early on
    run_phase(1023, 2, 1024);
    hold_req = 1'b1;

    run_small_phases(1250);

    // tallest frame via an out-of-range height, no idling on either side
    wait_drain();
    steady = 1'b1;
    run_phase(2, 511, 512);
    wait_drain();
    steady = 1'b0;

    run_small_phases(RANDOM_ITEMS);

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (expected_pixels.size() != 0) begin
      $display("%0t: %0d pixels never arrived", $time, expected_pixels.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* fire_effect_heat_propagator_core.f */
hw/rtl/fehp_pkg.sv
hw/rtl/fehp_heat_ram.sv
hw/rtl/fehp_scan_ctrl.sv
hw/rtl/fehp_out_queue.sv
hw/rtl/fire_effect_heat_propagator_core.sv
hw/rtl/fehp_checker.sv
verif/fire_effect_heat_propagator_core_tb.sv
